[rtl/core/nbody_direct_gravity_step_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef NBODY_DIRECT_GRAVITY_STEP_MACROS_SVH
`define NBODY_DIRECT_GRAVITY_STEP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NDGS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define NDGS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ndgs_pkg.sv]
package ndgs_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 1'd1;
  localparam logic [15:0]          TIME_STEP_RESET    = 16'd655;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         body_index;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic signed [31:0] in_vel_z;
    logic [31:0]        in_mass;
  } req_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic [31:0]        out_mass;
  } rsp_t;

  // operands of one pair evaluation
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        mass;
  } pair_in_t;

  // acceleration contribution of one pair
  typedef struct packed {
    logic signed [63:0] tx;
    logic signed [63:0] ty;
    logic signed [63:0] tz;
  } pair_out_t;

endpackage

[rtl/core/ndgs_ifs.sv]
interface ndgs_req_if;
  import ndgs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ndgs_rsp_if;
  import ndgs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/nbody_direct_gravity_step.sv]
// A write or a type 3 request is answered straight from IDLE; a read passes through ST_RD first.
// Step: each pair of distinct positions runs the iterative square root (32-bit root)
// and two shift-subtract divisions with 32+2*FRAC_BITS quotient bits each;
// coincident pairs skip the pair unit.
// One request in flight; the next is taken no earlier than the edge its result is taken.
// Reset clears control, particle_count to 0 and time_step to 655; body stores are not cleared.
`include "nbody_direct_gravity_step_macros.svh"

module nbody_direct_gravity_step #(
  parameter int MAX_PARTICLES = ndgs_pkg::MAX_PARTICLES_DEF,
  parameter int FRAC_BITS     = ndgs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ndgs_req_if.sink                          req,
  ndgs_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [ndgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ndgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ndgs_pkg::*;

  localparam int AW    = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic signed [63:0] ACC_LIM = (64'sd1 <<< 47) - 64'sd1;

  // Sequencer: IDLE takes one transaction. A step walks body i (LDI),
  // sweeps every j (RDJ/PAIR), applies dv = a*dt per axis (VMUL/VADD),
  // writes velocity (VWR); then a second sweep applies dp = v*dt (P*).
  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LDI, ST_LDI_W, ST_RDJ, ST_RDJ_W, ST_PAIR,
    ST_VMUL, ST_VADD, ST_VWR, ST_PRD, ST_PRD_W, ST_PMUL, ST_PADD,
    ST_PWR, ST_DONE
  } state_t;

  state_t state;

  // Body stores: one row per body, read data registered.
  logic signed [31:0] px_mem [MAX_PARTICLES];
  logic signed [31:0] py_mem [MAX_PARTICLES];
  logic signed [31:0] pz_mem [MAX_PARTICLES];
  logic signed [31:0] vx_mem [MAX_PARTICLES];
  logic signed [31:0] vy_mem [MAX_PARTICLES];
  logic signed [31:0] vz_mem [MAX_PARTICLES];
  logic [31:0]        m_mem  [MAX_PARTICLES];

  logic signed [31:0] rpx, rpy, rpz, rvx, rvy, rvz;
  logic [31:0]        rm;

  logic [10:0]        particle_count;
  logic [15:0]        time_step;

  logic               rsp_valid;
  rsp_t               rsp_data;
  logic               rd_ok;
  logic [CNT_W-1:0]   cnt_n;
  logic [AW-1:0]      bi, bj;
  logic signed [31:0] pix, piy, piz;
  logic signed [31:0] vreg [3];
  logic signed [31:0] preg [3];
  logic signed [63:0] acc  [3];
  logic [1:0]         axis;
  logic [62:0]        sprod;
  logic               pair_start;
  pair_in_t           pair_op;
  logic               pair_busy;
  logic               pair_done;
  pair_out_t          pair_terms;

  logic               acc_in;
  logic               idx_ok;
  logic [CNT_W-1:0]   n_eff;
  logic [AW-1:0]      raddr, waddr;
  logic               pos_we, vel_we, mass_we;
  logic signed [31:0] wpx, wpy, wpz, wvx, wvy, wvz;
  logic signed [32:0] dx, dy, dz;
  logic               j_last, i_last;
  logic signed [63:0] a_clamp;
  logic signed [63:0] a_neg;
  logic [46:0]        amag;
  logic signed [32:0] v_neg;
  logic [31:0]        vmag;
  logic [46:0]        smul_a;
  logic               sneg;
  logic signed [63:0] sh_mag;
  logic signed [63:0] dscaled;
  logic signed [63:0] upd_sum;
  logic signed [31:0] upd_base;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  assign acc_in    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    idx_ok = 32'(req.data.body_index) < 32'(MAX_PARTICLES);
    n_eff  = (32'(particle_count) < 32'(MAX_PARTICLES)) ?
             CNT_W'(particle_count) : CNT_W'(MAX_PARTICLES);
    j_last = CNT_W'(bj) == cnt_n - CNT_W'(1);
    i_last = CNT_W'(bi) == cnt_n - CNT_W'(1);

    // host writes land in IDLE; step write-backs use body i
    raddr = bi;
    case (state)
      ST_IDLE: raddr = AW'(req.data.body_index);
      ST_RDJ:  raddr = bj;
      default: raddr = bi;
    endcase
    waddr   = (state == ST_IDLE) ? AW'(req.data.body_index) : bi;
    mass_we = acc_in && req.data.req_type == REQ_WRITE && idx_ok;
    pos_we  = mass_we || state == ST_PWR;
    vel_we  = mass_we || state == ST_VWR;
    wpx = (state == ST_IDLE) ? req.data.in_pos_x : preg[0];
    wpy = (state == ST_IDLE) ? req.data.in_pos_y : preg[1];
    wpz = (state == ST_IDLE) ? req.data.in_pos_z : preg[2];
    wvx = (state == ST_IDLE) ? req.data.in_vel_x : vreg[0];
    wvy = (state == ST_IDLE) ? req.data.in_vel_y : vreg[1];
    wvz = (state == ST_IDLE) ? req.data.in_vel_z : vreg[2];

    dx = {rpx[31], rpx} - {pix[31], pix};
    dy = {rpy[31], rpy} - {piy[31], piy};
    dz = {rpz[31], rpz} - {piz[31], piz};

    // clamp |a| below 2^47 before scaling by dt
    a_clamp = acc[axis];
    if (acc[axis] > ACC_LIM) a_clamp = ACC_LIM;
    if (acc[axis] < -ACC_LIM) a_clamp = -ACC_LIM;
    a_neg = -a_clamp;
    amag  = a_clamp[63] ? a_neg[46:0] : a_clamp[46:0];
    v_neg = -{vreg[axis][31], vreg[axis]};
    vmag  = vreg[axis][31] ? v_neg[31:0] : vreg[axis][31:0];

    smul_a = (state == ST_PMUL) ? 47'(vmag) : amag;

    // add phase: sign(x) * floor(|x|*dt / 2^16)
    sneg     = (state == ST_PADD) ? vreg[axis][31] : acc[axis][63];
    upd_base = (state == ST_PADD) ? preg[axis] : vreg[axis];
    sh_mag   = $signed({17'd0, sprod[62:16]});
    dscaled  = sneg ? -sh_mag : sh_mag;
    upd_sum  = {{32{upd_base[31]}}, upd_base} + dscaled;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      px_mem[waddr] <= wpx;
      py_mem[waddr] <= wpy;
      pz_mem[waddr] <= wpz;
    end
    if (vel_we) begin
      vx_mem[waddr] <= wvx;
      vy_mem[waddr] <= wvy;
      vz_mem[waddr] <= wvz;
    end
    if (mass_we) begin
      m_mem[waddr] <= req.data.in_mass;
    end
    rpx <= px_mem[raddr];
    rpy <= py_mem[raddr];
    rpz <= pz_mem[raddr];
    rvx <= vx_mem[raddr];
    rvy <= vy_mem[raddr];
    rvz <= vz_mem[raddr];
    rm  <= m_mem[raddr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= '0;
      time_step      <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PARTICLE_COUNT: particle_count <= cfg_data[10:0];
        CFG_TIME_STEP:      time_step      <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      pair_start <= 1'b0;
    end else begin
      pair_start <= 1'b0;
      if (rsp.valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc_in) begin
            rsp_data <= rsp_t'{out_index: req.data.body_index, default: '0};
            rd_ok    <= idx_ok;
            case (req.data.req_type)
              REQ_READ: state <= ST_RD;
              REQ_STEP: begin
                cnt_n <= n_eff;
                bi    <= '0;
                state <= (n_eff == '0) ? ST_DONE : ST_LDI;
              end
              default:  rsp_valid <= 1'b1;
            endcase
          end
        end
        ST_RD: begin
          if (rd_ok) begin
            rsp_data.out_pos_x <= rpx;
            rsp_data.out_pos_y <= rpy;
            rsp_data.out_pos_z <= rpz;
            rsp_data.out_vel_x <= rvx;
            rsp_data.out_vel_y <= rvy;
            rsp_data.out_vel_z <= rvz;
            rsp_data.out_mass  <= rm;
          end
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_LDI: state <= ST_LDI_W;
        ST_LDI_W: begin
          pix     <= rpx;
          piy     <= rpy;
          piz     <= rpz;
          vreg[0] <= rvx;
          vreg[1] <= rvy;
          vreg[2] <= rvz;
          acc[0]  <= '0;
          acc[1]  <= '0;
          acc[2]  <= '0;
          bj      <= '0;
          state   <= ST_RDJ;
        end
        ST_RDJ: state <= ST_RDJ_W;
        ST_RDJ_W: begin
          if (dx == '0 && dy == '0 && dz == '0) begin
            // self or coincident body adds nothing
            if (j_last) begin
              axis  <= 2'd0;
              state <= ST_VMUL;
            end else begin
              bj    <= bj + 1'b1;
              state <= ST_RDJ;
            end
          end else begin
            pair_op    <= '{dx: dx, dy: dy, dz: dz, mass: rm};
            pair_start <= 1'b1;
            state      <= ST_PAIR;
          end
        end
        ST_PAIR: begin
          if (pair_done) begin
            acc[0] <= acc[0] + pair_terms.tx;
            acc[1] <= acc[1] + pair_terms.ty;
            acc[2] <= acc[2] + pair_terms.tz;
            if (j_last) begin
              axis  <= 2'd0;
              state <= ST_VMUL;
            end else begin
              bj    <= bj + 1'b1;
              state <= ST_RDJ;
            end
          end
        end
        ST_VMUL, ST_PMUL: begin
          sprod <= smul_a * time_step;
          state <= (state == ST_VMUL) ? ST_VADD : ST_PADD;
        end
        ST_VADD, ST_PADD: begin
          if (state == ST_VADD) vreg[axis] <= sat32(upd_sum);
          else                  preg[axis] <= sat32(upd_sum);
          if (axis == 2'd2) begin
            state <= (state == ST_VADD) ? ST_VWR : ST_PWR;
          end else begin
            axis  <= axis + 1'b1;
            state <= (state == ST_VADD) ? ST_VMUL : ST_PMUL;
          end
        end
        ST_VWR: begin
          if (i_last) begin
            bi    <= '0;
            state <= ST_PRD;
          end else begin
            bi    <= bi + 1'b1;
            state <= ST_LDI;
          end
        end
        ST_PRD: state <= ST_PRD_W;
        ST_PRD_W: begin
          preg[0] <= rpx;
          preg[1] <= rpy;
          preg[2] <= rpz;
          vreg[0] <= rvx;
          vreg[1] <= rvy;
          vreg[2] <= rvz;
          axis    <= 2'd0;
          state   <= ST_PMUL;
        end
        ST_PWR: begin
          if (i_last) begin
            state <= ST_DONE;
          end else begin
            bi    <= bi + 1'b1;
            state <= ST_PRD;
          end
        end
        ST_DONE: begin
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ndgs_pair #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pair (
    .clk   (clk),
    .rst   (rst),
    .start (pair_start),
    .op    (pair_op),
    .busy  (pair_busy),
    .done  (pair_done),
    .terms (pair_terms)
  );

  `NDGS_ASSERT_IMP(a_ready_idle, clk, rst, req.ready, state == ST_IDLE, "ready outside idle")
  `NDGS_ASSERT_IMP(a_pair_free, clk, rst, pair_start, !pair_busy, "pair unit restarted while busy")
  `NDGS_ASSERT_IMP(a_pos_we, clk, rst, pos_we, state == ST_IDLE || state == ST_PWR, "stray position write")
  `NDGS_ASSERT_NXT(a_step_rsp, clk, rst, state == ST_DONE, rsp_valid, "step result missing")

endmodule

[rtl/core/ndgs_pair.sv]
`include "nbody_direct_gravity_step_macros.svh"

module ndgs_pair #(
  parameter int FRAC_BITS = ndgs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ndgs_pkg::pair_in_t  op,
  output logic                busy,
  output logic                done,
  output ndgs_pkg::pair_out_t terms
);
  import ndgs_pkg::*;

  localparam int NUM_W = 32 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [63:0] SOFT =
    64'(((64'd25 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SUM, S_SQRT, S_DIVT, S_DIVK,
    S_TLO, S_THI, S_TACC
  } state_t;

  state_t state;

  logic [31:0]       mag [3];
  logic [2:0]        neg;
  logic [31:0]       mass;
  logic [1:0]        axis;
  logic [63:0]       prod;
  logic [63:0]       plo;
  logic [65:0]       r2sum;
  logic [63:0]       sq_v;
  logic [31:0]       sq_root;
  logic [35:0]       sq_rem;
  logic [NUM_W-1:0]  dvd;
  logic [63:0]       drem;
  logic [63:0]       dden;
  logic [63:0]       quo;
  logic [63:0]       kq;
  logic [CNT_W-1:0]  cnt;

  logic [1:0]        mul_sel;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [66:0]       r2_total;
  logic [63:0]       r2_sat;
  logic [35:0]       sq_sh;
  logic [35:0]       sq_trial;
  logic [64:0]       dr_sh;
  logic              dr_ge;
  logic [63:0]       quo_next;
  logic [63:0]       p64;
  logic [63:0]       pmag;
  logic signed [63:0] term;

  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic signed [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  always_comb begin
    case (state)
      S_SQX:   mul_sel = 2'd0;
      S_SQY:   mul_sel = 2'd1;
      S_SQZ:   mul_sel = 2'd2;
      default: mul_sel = axis;
    endcase
    mul_a = mag[mul_sel];
    case (state)
      S_TLO:   mul_b = kq[31:0];
      S_THI:   mul_b = kq[63:32];
      default: mul_b = mag[mul_sel];
    endcase

    r2_total = 67'(r2sum) + 67'(prod) + 67'(SOFT);
    r2_sat   = (r2_total[66:64] != 3'd0) ? '1 : r2_total[63:0];

    // restoring square root, two radicand bits per step
    sq_sh    = {sq_rem[33:0], sq_v[63:62]};
    sq_trial = {2'b00, sq_root, 2'b01};

    // restoring division, one quotient bit per step
    dr_sh    = {drem, dvd[NUM_W-1]};
    dr_ge    = dr_sh >= {1'b0, dden};
    quo_next = {quo[62:0], dr_ge};

    // product is taken modulo 2^64 before the fraction shift
    p64  = plo + {prod[31:0], 32'd0};
    pmag = p64 >> FRAC_BITS;
    term = neg[axis] ? -$signed(pmag) : $signed(pmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mag[0] <= mag33(op.dx);
            mag[1] <= mag33(op.dy);
            mag[2] <= mag33(op.dz);
            neg    <= {op.dz[32], op.dy[32], op.dx[32]};
            mass   <= op.mass;
            axis   <= 2'd0;
            state  <= S_SQX;
          end
        end
        S_SQX: begin
          prod  <= mul_a * mul_b;
          state <= S_SQY;
        end
        S_SQY: begin
          prod  <= mul_a * mul_b;
          r2sum <= 66'(prod);
          state <= S_SQZ;
        end
        S_SQZ: begin
          prod  <= mul_a * mul_b;
          r2sum <= r2sum + 66'(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          dden    <= r2_sat;
          sq_v    <= r2_sat;
          sq_root <= '0;
          sq_rem  <= '0;
          cnt     <= '0;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_sh >= sq_trial) begin
            sq_rem  <= sq_sh - sq_trial;
            sq_root <= {sq_root[30:0], 1'b1};
          end else begin
            sq_rem  <= sq_sh;
            sq_root <= {sq_root[30:0], 1'b0};
          end
          sq_v <= {sq_v[61:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(31)) begin
            dvd   <= NUM_W'(mass) << (2 * FRAC_BITS);
            drem  <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIVT;
          end
        end
        S_DIVT, S_DIVK: begin
          drem <= dr_ge ? dr_sh[63:0] - dden : dr_sh[63:0];
          dvd  <= {dvd[NUM_W-2:0], 1'b0};
          quo  <= quo_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            cnt  <= '0;
            drem <= '0;
            quo  <= '0;
            if (state == S_DIVT) begin
              // next quotient: the m/r2 quotient shifted left by FRAC_BITS, divided by sqrt(r2)
              dvd   <= NUM_W'(quo_next) << FRAC_BITS;
              dden  <= 64'(sq_root);
              state <= S_DIVK;
            end else begin
              kq    <= quo_next;
              axis  <= 2'd0;
              state <= S_TLO;
            end
          end
        end
        S_TLO: begin
          prod  <= mul_a * mul_b;
          state <= S_THI;
        end
        S_THI: begin
          plo   <= prod;
          prod  <= mul_a * mul_b;
          state <= S_TACC;
        end
        S_TACC: begin
          case (axis)
            2'd0:    terms.tx <= term;
            2'd1:    terms.ty <= term;
            default: terms.tz <= term;
          endcase
          if (axis == 2'd2) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_TLO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `NDGS_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE, "pair done while busy")
  `NDGS_ASSERT_NXT(a_start_go, clk, rst, start && state == S_IDLE, state == S_SQX, "pair start lost")
  `NDGS_ASSERT_IMP(a_div_nonzero, clk, rst, state == S_DIVK || state == S_DIVT, dden != 64'd0, "zero divisor")

endmodule
